>>> rtl/ccs_pkg.sv
// Package for the cell contour segments unit: register codes, fixed field
// widths, reset values and the divider result type.
// No dependencies.
package ccs_pkg;

   // configuration register indexes
   localparam logic [2:0] CFG_LEVEL_COUNT  = 3'd0;
   localparam logic [2:0] CFG_LEVEL_SELECT = 3'd1;
   localparam logic [2:0] CFG_LEVEL_VALUE  = 3'd2;
   localparam logic [2:0] CFG_TOLERANCE    = 3'd3;
   localparam logic [2:0] CFG_LABEL_ENABLE = 3'd4;
   localparam logic [2:0] CFG_LABEL_BASE   = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam int MAX_LEVELS_DEFAULT = 8;
   localparam int CORNERS            = 4;
   localparam int LEVEL_INDEX_W      = 3;

   // reset values
   localparam logic [3:0]  LEVEL_COUNT_RST = 4'd1;
   localparam logic [16:0] TOLERANCE_RST   = 17'd65535;
   localparam logic [7:0]  LABEL_BASE_RST  = 8'd64;

   // label counter: a label is placed once the counter passes this value
   localparam logic [3:0] LABEL_THRESHOLD = 4'd9;
   localparam logic [3:0] COUNTER_MAX     = 4'd15;

   // crossing fraction limit, Q.16 one times 2^14
   localparam logic [31:0] FB_LIMIT = 32'h4000_0000;

   // divider widths: numerator magnitude, divisor magnitude, quotient
   localparam int DIV_N_W = 49;
   localparam int DIV_D_W = 33;
   localparam int DIV_Q_W = 32;

   typedef struct packed {
      logic               done;
      logic               ovf;
      logic               rem_nz;
      logic [DIV_Q_W-1:0] quo;
   } div_res_type;

endpackage

>>> rtl/ccs_if.sv
// Handshake channels of the cell contour segments unit: cell words in,
// segment words out.
// Depends on nothing.
interface ccs_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] corner_value_0;
   logic signed [31:0] corner_value_1;
   logic signed [31:0] corner_value_2;
   logic signed [31:0] corner_value_3;
   logic signed [31:0] corner_x_0;
   logic signed [31:0] corner_x_1;
   logic signed [31:0] corner_x_2;
   logic signed [31:0] corner_x_3;
   logic signed [31:0] corner_y_0;
   logic signed [31:0] corner_y_1;
   logic signed [31:0] corner_y_2;
   logic signed [31:0] corner_y_3;

   modport source (output valid, corner_value_0, corner_value_1, corner_value_2,
                   corner_value_3, corner_x_0, corner_x_1, corner_x_2, corner_x_3,
                   corner_y_0, corner_y_1, corner_y_2, corner_y_3, input ready);
   modport sink (input valid, corner_value_0, corner_value_1, corner_value_2,
                 corner_value_3, corner_x_0, corner_x_1, corner_x_2, corner_x_3,
                 corner_y_0, corner_y_1, corner_y_2, corner_y_3, output ready);
endinterface

interface ccs_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         level_index;
   logic               segment_kind;
   logic signed [31:0] start_x;
   logic signed [31:0] start_y;
   logic signed [31:0] end_x;
   logic signed [31:0] end_y;
   logic               label_valid;
   logic [7:0]         label_char;
   logic signed [31:0] label_x;
   logic signed [31:0] label_y;
   logic               last;

   modport source (output valid, level_index, segment_kind, start_x, start_y,
                   end_x, end_y, label_valid, label_char, label_x, label_y, last,
                   input ready);
   modport sink (input valid, level_index, segment_kind, start_x, start_y,
                 end_x, end_y, label_valid, label_char, label_x, label_y, last,
                 output ready);
endinterface

>>> rtl/cell_contour_segments_unit.sv
// Contour lines through one quadrilateral mesh cell. Per cell word the unit
// walks the levels in use and, per level, the edges 0-1, 1-2, 2-3, 3-0. An
// edge that crosses adds one pass of the shared 32-step divider plus a
// multiply and round for x and then for y. A level with more than two
// crossings also divides for its mean point, and each emitted word waits
// while the output is stalled. The unit takes no new cell while it works
// on one, and the last segment word of a cell carries last.
module cell_contour_segments_unit #(
   parameter int MAX_LEVELS = ccs_pkg::MAX_LEVELS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   ccs_req_if.sink                         req_port,
   ccs_rsp_if.source                       rsp_port,
   input  logic                            csr_we,
   input  logic [ccs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ccs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int CNT_W = $clog2(MAX_LEVELS + 1);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_LEV     = 4'd1;
   localparam logic [3:0] ST_TMUL    = 4'd2;
   localparam logic [3:0] ST_EDGE    = 4'd3;
   localparam logic [3:0] ST_DIV     = 4'd4;
   localparam logic [3:0] ST_MUL     = 4'd5;
   localparam logic [3:0] ST_ADD     = 4'd6;
   localparam logic [3:0] ST_LEVEND  = 4'd7;
   localparam logic [3:0] ST_SEG     = 4'd8;
   localparam logic [3:0] ST_MEAN    = 4'd9;
   localparam logic [3:0] ST_MDIV    = 4'd10;
   localparam logic [3:0] ST_SPOKE   = 4'd11;
   localparam logic [3:0] ST_NEXTLEV = 4'd12;
   localparam logic [3:0] ST_FLUSH   = 4'd13;

   typedef struct packed {
      logic [2:0]         level_index;
      logic               segment_kind;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic               label_valid;
      logic [7:0]         label_char;
      logic signed [31:0] label_x;
      logic signed [31:0] label_y;
      logic               last;
   } result_type;

   // configuration
   logic [3:0]         level_count_ff, level_count_in;
   logic [2:0]         level_select_ff, level_select_in;
   logic [16:0]        tolerance_ff, tolerance_in;
   logic               label_enable_ff, label_enable_in;
   logic [7:0]         label_base_ff, label_base_in;
   logic signed [31:0] level_tbl_ff [MAX_LEVELS];
   logic signed [31:0] level_tbl_in [MAX_LEVELS];

   // cell and sequencer
   logic [3:0]         state_ff, state_in;
   logic signed [31:0] val_ff [ccs_pkg::CORNERS];
   logic signed [31:0] val_in [ccs_pkg::CORNERS];
   logic signed [31:0] px_ff [ccs_pkg::CORNERS];
   logic signed [31:0] px_in [ccs_pkg::CORNERS];
   logic signed [31:0] py_ff [ccs_pkg::CORNERS];
   logic signed [31:0] py_in [ccs_pkg::CORNERS];
   logic signed [31:0] cx_ff [ccs_pkg::CORNERS];
   logic signed [31:0] cx_in [ccs_pkg::CORNERS];
   logic signed [31:0] cy_ff [ccs_pkg::CORNERS];
   logic signed [31:0] cy_in [ccs_pkg::CORNERS];
   logic [3:0]         lbl_cnt_ff [MAX_LEVELS];
   logic [3:0]         lbl_cnt_in [MAX_LEVELS];
   logic [CNT_W-1:0]   nlev_ff, nlev_in;
   logic [CNT_W-1:0]   lvl_ff, lvl_in;
   logic signed [31:0] lv_ff, lv_in;
   logic signed [49:0] thr_ff, thr_in;
   logic [1:0]         edge_idx_ff, edge_idx_in;
   logic [2:0]         n_ff, n_in;
   logic               coord_ff, coord_in;
   logic [1:0]         spk_ff, spk_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] fb_ff, fb_in;
   logic signed [64:0] prod_ff, prod_in;
   logic signed [31:0] mx_ff, mx_in;
   logic signed [31:0] my_ff, my_in;

   // output staging: one held-back word so that last can be set
   result_type         pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;
   result_type         rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // divider
   logic                        div_start;
   logic [ccs_pkg::DIV_N_W-1:0] div_num;
   logic [ccs_pkg::DIV_D_W-1:0] div_den;
   ccs_pkg::div_res_type        div_res;

   // edge datapath
   logic [1:0]         nxt_idx;
   logic [LVL_W-1:0]   lvl_idx;
   logic signed [31:0] a1, a2, p1, p2;
   logic signed [49:0] big_a1, big_a2;
   logic               crosses;
   logic signed [32:0] dval, dnum, dpos;
   logic signed [48:0] num_s;
   logic [31:0]        fb_mag;
   logic signed [64:0] rnd_sum, pos_sum;
   logic signed [31:0] pos_sat;
   logic signed [33:0] msum;
   logic [32:0]        q_ext;
   logic signed [32:0] mid_x, mid_y;
   logic               slot_free;
   logic [3:0]         cnt_cur;
   result_type         new_res;

   ccs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .res   (div_res)
   );

   assign nxt_idx = edge_idx_ff + 2'd1;
   assign lvl_idx = lvl_ff[LVL_W-1:0];
   assign cnt_cur = lbl_cnt_ff[lvl_idx];
   assign slot_free = !rsp_valid_ff || rsp_port.ready;

   // crossing test and division operands for the current edge
   always_comb begin
      a1 = val_ff[edge_idx_ff];
      a2 = val_ff[nxt_idx];
      big_a1 = {{2{a1[31]}}, a1, 16'h0000};
      big_a2 = {{2{a2[31]}}, a2, 16'h0000};
      crosses = (big_a1 < thr_ff && thr_ff <= big_a2) ||
                (big_a2 < thr_ff && thr_ff <= big_a1);
      dval = {a2[31], a2} - {a1[31], a1};
      dnum = {lv_ff[31], lv_ff} - {a1[31], a1};
      num_s = {dnum, 16'h0000};
   end

   // interpolation operands and rounded, saturated position
   always_comb begin
      p1 = coord_ff ? py_ff[edge_idx_ff] : px_ff[edge_idx_ff];
      p2 = coord_ff ? py_ff[nxt_idx] : px_ff[nxt_idx];
      dpos = {p2[31], p2} - {p1[31], p1};
      rnd_sum = prod_ff + 65'sd32768;
      pos_sum = {{33{p1[31]}}, p1} + {{16{rnd_sum[64]}}, rnd_sum[64:16]};
      if (pos_sum > 65'sd2147483647) begin
         pos_sat = 32'sh7fff_ffff;
      end else if (pos_sum < -65'sd2147483648) begin
         pos_sat = 32'sh8000_0000;
      end else begin
         pos_sat = pos_sum[31:0];
      end
   end

   // sums for the mean point and the label midpoint
   always_comb begin
      if (!coord_ff) begin
         msum = 34'(cx_ff[0]) + 34'(cx_ff[1]) + 34'(cx_ff[2]);
         if (n_ff == 3'd4) begin
            msum = msum + 34'(cx_ff[3]);
         end
      end else begin
         msum = 34'(cy_ff[0]) + 34'(cy_ff[1]) + 34'(cy_ff[2]);
         if (n_ff == 3'd4) begin
            msum = msum + 34'(cy_ff[3]);
         end
      end
      mid_x = ({cx_ff[0][31], cx_ff[0]} + {cx_ff[1][31], cx_ff[1]}) >>> 1;
      mid_y = ({cy_ff[0][31], cy_ff[0]} + {cy_ff[1][31], cy_ff[1]}) >>> 1;
      q_ext = {1'b0, div_res.quo};
      fb_mag = (div_res.ovf || div_res.quo > ccs_pkg::FB_LIMIT) ?
               ccs_pkg::FB_LIMIT : div_res.quo;
   end

   // sequencer and next values
   always_comb begin
      level_count_in  = level_count_ff;
      level_select_in = level_select_ff;
      tolerance_in    = tolerance_ff;
      label_enable_in = label_enable_ff;
      label_base_in   = label_base_ff;
      level_tbl_in    = level_tbl_ff;
      state_in        = state_ff;
      val_in          = val_ff;
      px_in           = px_ff;
      py_in           = py_ff;
      cx_in           = cx_ff;
      cy_in           = cy_ff;
      lbl_cnt_in      = lbl_cnt_ff;
      nlev_in         = nlev_ff;
      lvl_in          = lvl_ff;
      lv_in           = lv_ff;
      thr_in          = thr_ff;
      edge_idx_in     = edge_idx_ff;
      n_in            = n_ff;
      coord_in        = coord_ff;
      spk_in          = spk_ff;
      neg_in          = neg_ff;
      fb_in           = fb_ff;
      prod_in         = prod_ff;
      mx_in           = mx_ff;
      my_in           = my_ff;
      pend_in         = pend_ff;
      pend_valid_in   = pend_valid_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff;
      div_start       = 1'b0;
      div_num         = '0;
      div_den         = '0;
      new_res         = '0;
      new_res.level_index = ccs_pkg::LEVEL_INDEX_W'(lvl_ff);

      // drop the output word once taken
      if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            ccs_pkg::CFG_LEVEL_COUNT:  level_count_in  = csr_wdata[3:0];
            ccs_pkg::CFG_LEVEL_SELECT: level_select_in = csr_wdata[2:0];
            ccs_pkg::CFG_LEVEL_VALUE: begin
               if (int'(level_select_ff) < MAX_LEVELS) begin
                  level_tbl_in[LVL_W'(level_select_ff)] = csr_wdata;
               end
            end
            ccs_pkg::CFG_TOLERANCE:    tolerance_in    = csr_wdata[16:0];
            ccs_pkg::CFG_LABEL_ENABLE: label_enable_in = csr_wdata[0];
            ccs_pkg::CFG_LABEL_BASE:   label_base_in   = csr_wdata[7:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               val_in[0] = req_port.corner_value_0;
               val_in[1] = req_port.corner_value_1;
               val_in[2] = req_port.corner_value_2;
               val_in[3] = req_port.corner_value_3;
               px_in[0]  = req_port.corner_x_0;
               px_in[1]  = req_port.corner_x_1;
               px_in[2]  = req_port.corner_x_2;
               px_in[3]  = req_port.corner_x_3;
               py_in[0]  = req_port.corner_y_0;
               py_in[1]  = req_port.corner_y_1;
               py_in[2]  = req_port.corner_y_2;
               py_in[3]  = req_port.corner_y_3;
               nlev_in = (int'(level_count_ff) < MAX_LEVELS) ?
                         CNT_W'(level_count_ff) : CNT_W'(MAX_LEVELS);
               lvl_in = '0;
               state_in = (level_count_ff == 4'd0) ? ST_FLUSH : ST_LEV;
            end
         end
         ST_LEV: begin
            lv_in = level_tbl_ff[lvl_idx];
            edge_idx_in = 2'd0;
            n_in = 3'd0;
            coord_in = 1'b0;
            state_in = ST_TMUL;
         end
         ST_TMUL: begin
            thr_in = $signed({1'b0, tolerance_ff}) * lv_ff;
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            if (crosses && dval != '0) begin
               div_start = 1'b1;
               div_num = num_s[48] ? 49'(-num_s) : num_s;
               div_den = dval[32] ? 33'(-dval) : dval;
               neg_in = num_s[48] ^ dval[32];
               state_in = ST_DIV;
            end else if (edge_idx_ff == 2'd3) begin
               state_in = ST_LEVEND;
            end else begin
               edge_idx_in = nxt_idx;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               fb_in = neg_ff ? -$signed(fb_mag) : $signed(fb_mag);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = fb_ff * dpos;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (!coord_ff) begin
               cx_in[n_ff[1:0]] = pos_sat;
               coord_in = 1'b1;
               state_in = ST_MUL;
            end else begin
               cy_in[n_ff[1:0]] = pos_sat;
               coord_in = 1'b0;
               n_in = n_ff + 3'd1;
               if (edge_idx_ff == 2'd3) begin
                  state_in = ST_LEVEND;
               end else begin
                  edge_idx_in = nxt_idx;
                  state_in = ST_EDGE;
               end
            end
         end
         ST_LEVEND: begin
            if (n_ff == 3'd2) begin
               state_in = ST_SEG;
            end else if (n_ff > 3'd2) begin
               if (cnt_cur < ccs_pkg::COUNTER_MAX) begin
                  lbl_cnt_in[lvl_idx] = cnt_cur + 4'd1;
               end
               coord_in = 1'b0;
               state_in = ST_MEAN;
            end else begin
               state_in = ST_NEXTLEV;
            end
         end
         ST_SEG: begin
            new_res.segment_kind = 1'b0;
            new_res.start_x = cx_ff[0];
            new_res.start_y = cy_ff[0];
            new_res.end_x   = cx_ff[1];
            new_res.end_y   = cy_ff[1];
            if (label_enable_ff && cnt_cur > ccs_pkg::LABEL_THRESHOLD) begin
               new_res.label_valid = 1'b1;
               new_res.label_char  = label_base_ff + 8'(lvl_ff);
               new_res.label_x     = mid_x[31:0];
               new_res.label_y     = mid_y[31:0];
            end
            if (slot_free) begin
               if (label_enable_ff) begin
                  if (cnt_cur > ccs_pkg::LABEL_THRESHOLD) begin
                     lbl_cnt_in[lvl_idx] = 4'd0;
                  end else if (cnt_cur < ccs_pkg::COUNTER_MAX) begin
                     lbl_cnt_in[lvl_idx] = cnt_cur + 4'd1;
                  end
               end
               if (pend_valid_ff) begin
                  rsp_in = pend_ff;
                  rsp_valid_in = 1'b1;
               end
               pend_in = new_res;
               pend_valid_in = 1'b1;
               state_in = ST_NEXTLEV;
            end
         end
         ST_MEAN: begin
            div_start = 1'b1;
            div_num = ccs_pkg::DIV_N_W'(msum[33] ? 34'(-msum) : msum);
            div_den = ccs_pkg::DIV_D_W'(n_ff);
            neg_in = msum[33];
            state_in = ST_MDIV;
         end
         ST_MDIV: begin
            if (div_res.done) begin
               if (!coord_ff) begin
                  mx_in = neg_ff ? 32'(-(q_ext + 33'(div_res.rem_nz))) : div_res.quo;
                  coord_in = 1'b1;
                  state_in = ST_MEAN;
               end else begin
                  my_in = neg_ff ? 32'(-(q_ext + 33'(div_res.rem_nz))) : div_res.quo;
                  coord_in = 1'b0;
                  spk_in = 2'd0;
                  state_in = ST_SPOKE;
               end
            end
         end
         ST_SPOKE: begin
            new_res.segment_kind = 1'b1;
            new_res.start_x = mx_ff;
            new_res.start_y = my_ff;
            new_res.end_x   = cx_ff[spk_ff];
            new_res.end_y   = cy_ff[spk_ff];
            if (slot_free) begin
               if (pend_valid_ff) begin
                  rsp_in = pend_ff;
                  rsp_valid_in = 1'b1;
               end
               pend_in = new_res;
               pend_valid_in = 1'b1;
               spk_in = spk_ff + 2'd1;
               if ({1'b0, spk_ff} == n_ff - 3'd1) begin
                  state_in = ST_NEXTLEV;
               end
            end
         end
         ST_NEXTLEV: begin
            lvl_in = lvl_ff + 1'b1;
            state_in = (lvl_in == nlev_ff) ? ST_FLUSH : ST_LEV;
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               rsp_in = pend_ff;
               rsp_in.last = 1'b1;
               rsp_valid_in = 1'b1;
               pend_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff  <= ccs_pkg::LEVEL_COUNT_RST;
         level_select_ff <= '0;
         tolerance_ff    <= ccs_pkg::TOLERANCE_RST;
         label_enable_ff <= 1'b0;
         label_base_ff   <= ccs_pkg::LABEL_BASE_RST;
         state_ff        <= ST_IDLE;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            lbl_cnt_ff[i] <= '0;
         end
      end else begin
         level_count_ff  <= level_count_in;
         level_select_ff <= level_select_in;
         tolerance_ff    <= tolerance_in;
         label_enable_ff <= label_enable_in;
         label_base_ff   <= label_base_in;
         state_ff        <= state_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         lbl_cnt_ff      <= lbl_cnt_in;
      end
      level_tbl_ff <= level_tbl_in;
      val_ff       <= val_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      nlev_ff      <= nlev_in;
      lvl_ff       <= lvl_in;
      lv_ff        <= lv_in;
      thr_ff       <= thr_in;
      edge_idx_ff  <= edge_idx_in;
      n_ff         <= n_in;
      coord_ff     <= coord_in;
      spk_ff       <= spk_in;
      neg_ff       <= neg_in;
      fb_ff        <= fb_in;
      prod_ff      <= prod_in;
      mx_ff        <= mx_in;
      my_ff        <= my_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
   end

   // ports
   assign req_port.ready        = state_ff == ST_IDLE;
   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.level_index  = rsp_ff.level_index;
   assign rsp_port.segment_kind = rsp_ff.segment_kind;
   assign rsp_port.start_x      = rsp_ff.start_x;
   assign rsp_port.start_y      = rsp_ff.start_y;
   assign rsp_port.end_x        = rsp_ff.end_x;
   assign rsp_port.end_y        = rsp_ff.end_y;
   assign rsp_port.label_valid  = rsp_ff.label_valid;
   assign rsp_port.label_char   = rsp_ff.label_char;
   assign rsp_port.label_x      = rsp_ff.label_x;
   assign rsp_port.label_y      = rsp_ff.label_y;
   assign rsp_port.last         = rsp_ff.last;

   // no held-back word survives the end of a cell
   a_flushed: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff) else $error("word left pending");
   // at most one crossing per edge, so at most four per level
   a_ncross: assert property (@(posedge clock) disable iff (reset)
      n_ff <= 3'd4) else $error("crossing count overflow");
   // an accepted cell closes the input until its work is done
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> !req_port.ready)
      else $error("input open while busy");
   // the divider is only waited on after it was started
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EDGE && state_in == ST_DIV) |-> div_start)
      else $error("division not started");
endmodule

>>> rtl/ccs_div.sv
// Iterative unsigned divider of the cell contour segments unit, one
// quotient bit per cycle, with an overflow flag for quotients past 32 bits.
// Depends on ccs_pkg.
module ccs_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ccs_pkg::DIV_N_W-1:0]  num,
   input  logic [ccs_pkg::DIV_D_W-1:0]  den,
   output ccs_pkg::div_res_type         res
);
   localparam int SH_W  = ccs_pkg::DIV_D_W + ccs_pkg::DIV_Q_W - 1;
   localparam int CNT_W = $clog2(ccs_pkg::DIV_Q_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic                        ovf_ff, ovf_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [ccs_pkg::DIV_N_W-1:0] rem_ff, rem_in;
   logic [SH_W-1:0]             dsh_ff, dsh_in;
   logic [ccs_pkg::DIV_Q_W-1:0] quo_ff, quo_in;
   logic                        ge;

   assign ge = {{(SH_W - ccs_pkg::DIV_N_W){1'b0}}, rem_ff} >= dsh_ff;

   // start, then one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         ovf_in = {{(ccs_pkg::DIV_D_W - 1){1'b0}}, num} >= {den, {ccs_pkg::DIV_Q_W{1'b0}}};
         rem_in = num;
         dsh_in = {den, {(ccs_pkg::DIV_Q_W - 1){1'b0}}};
         quo_in = '0;
         cnt_in = '1;
         busy_in = !ovf_in;
         done_in = ovf_in;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff[ccs_pkg::DIV_N_W-1:0];
         end
         quo_in = {quo_ff[ccs_pkg::DIV_Q_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign res.done   = done_ff;
   assign res.ovf    = ovf_ff;
   assign res.rem_nz = rem_ff != '0;
   assign res.quo    = quo_ff;

   // a new division never starts on top of a running one
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   // an overflowing division finishes in the cycle after its start
   a_ovf_fast: assert property (@(posedge clock) disable iff (reset)
      (start && ovf_in) |=> done_ff) else $error("overflow not reported at once");
   // done never comes while the divider still iterates
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
endmodule
